// ===== hw/rtl/ers_pkg.sv =====
package ers_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;

  localparam int SAT_W = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam logic [63:0] SAT_MAX     = (64'd1 << (SAT_W - 1)) - 64'd1;
  localparam logic [63:0] SAT_NEG_MAG = 64'd1 << (SAT_W - 1);

  // The first axis length stays below 2^31, so the quotient needs this many steps.
  localparam int DIVW     = 31 + FRAC_BITS;
  localparam int SQ_STEPS = 32;
  localparam int BD_STEPS = 32;

  localparam logic [63:0] PI_Q30        = 64'd3373259426;
  localparam logic [63:0] SQRT2_Q30     = 64'd1518500250;
  localparam logic [63:0] INV_SQRT2_Q30 = 64'd759250125;
  localparam logic [63:0] PISQ2_Q30     = (PI_Q30 * SQRT2_Q30 + (64'd1 << 29)) >> 30;
  localparam logic [16:0] PISQ2_HI      = 17'(PISQ2_Q30 >> 16);
  localparam logic [15:0] PISQ2_LO      = 16'(PISQ2_Q30 & 64'hffff);

  localparam logic [63:0] W_ODD_FULL = (FRAC_BITS < 30) ?
      ((INV_SQRT2_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS)) : INV_SQRT2_Q30;
  localparam logic [16:0] W_ODD  = 17'(W_ODD_FULL);
  localparam logic [16:0] W_EVEN = 17'(64'd1 << FRAC_BITS);
  localparam logic [31:0] ONE_Q  = 32'(64'd1 << FRAC_BITS);

  localparam logic [3:0] KNOT_LAST  = 4'd11;
  localparam logic [3:0] POINT_CNT  = 4'd9;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_AXIS_ZERO = 2'd1,
    ST_PARALLEL  = 2'd2
  } status_t;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic             d3;
    status_t          status;
    vec3_t            c;
    vec3_t            a;
    logic [31:0]      rat;
    logic [2:0][30:0] crm;
    logic [2:0]       ng;
  } ctx_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [63:0] num;
    logic [63:0] q;
  } dv_t;

  typedef struct packed {
    logic [63:0]      m;
    logic [2:0][63:0] g;
  } nrm_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // One digit of the bitwise integer square root.
  function automatic sq_t isq_step(input sq_t s, input logic [63:0] bitv);
    sq_t o;
    logic [63:0] t;
    t = s.r + bitv;
    if (s.x >= t) begin
      o.x = s.x - t;
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // One quotient bit of a restoring divide; the dividend is left aligned in num.
  function automatic dv_t div_step(input dv_t s, input logic [31:0] d);
    dv_t o;
    logic [32:0] r;
    r = {s.rem[31:0], s.num[63]};
    o.num = s.num << 1;
    if (r >= {1'b0, d}) begin
      o.rem = r - {1'b0, d};
      o.q   = {s.q[62:0], 1'b1};
    end else begin
      o.rem = r;
      o.q   = {s.q[62:0], 1'b0};
    end
    return o;
  endfunction

  // Passes one and two bring the largest magnitude down, three and four bring it up.
  function automatic nrm_t norm_pass(input nrm_t s, input int pass);
    nrm_t o;
    int   sh;
    o = s;
    for (int k = 0; k < 3; k++) begin
      if (pass == 1) sh = 32 >> k;
      else if (pass == 2) sh = 4 >> k;
      else if (pass == 3) sh = 16 >> k;
      else sh = (k < 2) ? (2 >> k) : 0;
      if (sh > 0) begin
        if (pass <= 2) begin
          if (o.m >= (64'd1 << (30 + sh))) begin
            o.m = o.m >> sh;
            for (int i = 0; i < 3; i++) o.g[i] = o.g[i] >> sh;
          end
        end else if (o.m < (64'd1 << (31 - sh))) begin
          o.m = o.m << sh;
          for (int i = 0; i < 3; i++) o.g[i] = o.g[i] << sh;
        end
      end
    end
    return o;
  endfunction

  // Saturating signed result from a magnitude and a sign.
  function automatic logic [31:0] sat_neg(input logic [63:0] q, input logic neg);
    logic [63:0] m;
    if (neg) begin
      m = (q > SAT_NEG_MAG) ? SAT_NEG_MAG : q;
      m = 64'd0 - m;
    end else begin
      m = (q > SAT_MAX) ? SAT_MAX : q;
    end
    return m[31:0];
  endfunction

  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    if (w > $signed(SAT_MAX)) w = $signed(SAT_MAX);
    else if (w < -$signed(SAT_MAX) - 64'sd1) w = -$signed(SAT_MAX) - 64'sd1;
    return w[31:0];
  endfunction

endpackage

// ===== hw/rtl/ellipse_to_rational_spline_core.sv =====
// A valid ellipse gives twelve result beats on consecutive cycles; an error gives one.
// The pipeline takes new ellipses while earlier ones are in flight; the result port sets the pace.
// The arithmetic pipeline stalls as a whole while a finished ellipse waits at its last
// stage and the sequencer still emits the beats of the one before.
// Reset (rst, synchronous) empties the pipeline and the sequencer; the receiver cannot stall.
module ellipse_to_rational_spline_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic signed [31:0] normal_z,
  input  logic signed [31:0] centre_x,
  input  logic signed [31:0] centre_y,
  input  logic signed [31:0] centre_z,
  input  logic signed [31:0] axis_x,
  input  logic signed [31:0] axis_y,
  input  logic signed [31:0] axis_z,
  input  logic signed [31:0] axis_ratio,
  input  logic               use_3d,
  output logic               strobe,
  output logic [3:0]         knot_index,
  output logic [30:0]        knot_value,
  output logic               has_point,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic [16:0]        point_weight,
  output logic [1:0]         status,
  output logic               last
);
  import ers_pkg::*;

  logic stall, adv;
  assign adv  = !stall;
  assign busy = stall;

  // Input stage.
  logic  v0;
  ctx_t  x0;
  vec3_t n0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0        <= start;
      x0.d3     <= use_3d;
      x0.status <= ST_OK;
      x0.c      <= {use_3d ? centre_z : 32'd0, centre_y, centre_x};
      x0.a      <= {use_3d ? axis_z : 32'd0, axis_y, axis_x};
      x0.rat    <= (axis_ratio == 32'd0) ? ONE_Q : axis_ratio;
      x0.crm    <= '0;
      x0.ng     <= '0;
      n0        <= {normal_z, normal_y, normal_x};
    end
  end

  // Squares of the axis and the six cross product terms.
  logic             v1;
  ctx_t             x1;
  logic [2:0][63:0] sq1;
  logic [5:0][63:0] pr1;
  logic [2:0][63:0] sq_c;
  logic [5:0][63:0] pr_c;

  always_comb begin
    for (int i = 0; i < 3; i++) sq_c[i] = mag32(x0.a[i]) * mag32(x0.a[i]);
    pr_c[0] = $signed(n0[1]) * $signed(x0.a[2]);
    pr_c[1] = $signed(n0[2]) * $signed(x0.a[1]);
    pr_c[2] = $signed(n0[2]) * $signed(x0.a[0]);
    pr_c[3] = $signed(n0[0]) * $signed(x0.a[2]);
    pr_c[4] = $signed(n0[0]) * $signed(x0.a[1]);
    pr_c[5] = $signed(n0[1]) * $signed(x0.a[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1  <= v0;
      x1  <= x0;
      sq1 <= sq_c;
      pr1 <= pr_c;
    end
  end

  // Sum of squares and second axis direction as magnitude and sign.
  logic             v2;
  ctx_t             x2;
  logic [63:0]      sum2;
  logic [2:0][63:0] mg2;
  logic [63:0]      sum_c;
  logic [2:0][63:0] mg_c;
  logic [2:0]       ng_c;
  ctx_t             x2_c;

  always_comb begin
    logic signed [64:0] d;
    logic signed [64:0] dn;
    sum_c = sq1[0] + sq1[1] + sq1[2];
    for (int i = 0; i < 3; i++) begin
      d       = $signed(pr1[2*i]) - $signed(pr1[2*i+1]);
      dn      = -d;
      mg_c[i] = d[64] ? dn[63:0] : d[63:0];
      ng_c[i] = d[64];
    end
    if (!x1.d3) begin
      mg_c[0] = {32'd0, mag32(x1.a[1])};
      ng_c[0] = !x1.a[1][31] && (x1.a[1] != 32'd0);
      mg_c[1] = {32'd0, mag32(x1.a[0])};
      ng_c[1] = x1.a[0][31];
      mg_c[2] = '0;
      ng_c[2] = 1'b0;
    end
    x2_c    = x1;
    x2_c.ng = ng_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2    <= v1;
      x2    <= x2_c;
      sum2  <= sum_c;
      mg2   <= mg_c;
    end
  end

  // Largest component and the error checks; then four normalizing passes.
  logic        nv [5];
  ctx_t        nx [5];
  logic [63:0] ns [5];
  nrm_t        nr [5];
  logic [63:0] max_c;
  status_t     st_c;
  ctx_t        nx_c;

  always_comb begin
    max_c = mg2[0];
    if (mg2[1] > max_c) max_c = mg2[1];
    if (mg2[2] > max_c) max_c = mg2[2];
    if (sum2 == 64'd0) st_c = ST_AXIS_ZERO;
    else if (max_c == 64'd0) st_c = ST_PARALLEL;
    else st_c = ST_OK;
    nx_c        = x2;
    nx_c.status = st_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nv[0] <= 1'b0;
    end else if (adv) begin
      nv[0]        <= v2;
      nx[0]        <= nx_c;
      ns[0]        <= sum2;
      nr[0].m      <= max_c;
      nr[0].g      <= mg2;
    end
  end

  for (genvar j = 1; j < 5; j++) begin : g_norm
    always_ff @(posedge clk) begin
      if (rst) begin
        nv[j] <= 1'b0;
      end else if (adv) begin
        nv[j] <= nv[j-1];
        nx[j] <= nx[j-1];
        ns[j] <= ns[j-1];
        nr[j] <= norm_pass(nr[j-1], j);
      end
    end
  end

  // Squares of the normalized direction.
  logic             v8;
  ctx_t             x8;
  logic [63:0]      sum8;
  logic [2:0][63:0] cq8;
  ctx_t             x8_c;

  always_comb begin
    x8_c = nx[4];
    for (int i = 0; i < 3; i++) x8_c.crm[i] = nr[4].g[i][30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8   <= nv[4];
      x8   <= x8_c;
      sum8 <= ns[4];
      for (int i = 0; i < 3; i++) begin
        cq8[i]    <= nr[4].g[i][30:0] * nr[4].g[i][30:0];
      end
    end
  end

  // Two square roots side by side: first axis length and direction length.
  logic s1v [SQ_STEPS+1];
  ctx_t s1x [SQ_STEPS+1];
  sq_t  s1  [SQ_STEPS+1][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v[0] <= 1'b0;
    end else if (adv) begin
      s1v[0]   <= v8;
      s1x[0]   <= x8;
      s1[0][0] <= {sum8, 64'd0};
      s1[0][1] <= {cq8[0] + cq8[1] + cq8[2], 64'd0};
    end
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq1
    always_ff @(posedge clk) begin
      if (rst) begin
        s1v[j+1] <= 1'b0;
      end else if (adv) begin
        s1v[j+1]   <= s1v[j];
        s1x[j+1]   <= s1x[j];
        s1[j+1][0] <= isq_step(s1[j][0], 64'd1 << (62 - 2*j));
        s1[j+1][1] <= isq_step(s1[j][1], 64'd1 << (62 - 2*j));
      end
    end
  end

  // Second axis length: (ell << FRAC_BITS) / |ratio|.
  logic        d1v [DIVW+1];
  ctx_t        d1x [DIVW+1];
  logic [30:0] d1e [DIVW+1];
  logic [31:0] d1c [DIVW+1];
  dv_t         d1  [DIVW+1];
  logic [30:0] ell_c;

  assign ell_c = (s1[SQ_STEPS][0].r > SAT_MAX) ? SAT_MAX[30:0] : s1[SQ_STEPS][0].r[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      d1v[0] <= 1'b0;
    end else if (adv) begin
      d1v[0]     <= s1v[SQ_STEPS];
      d1x[0]     <= s1x[SQ_STEPS];
      d1e[0]     <= ell_c;
      d1c[0]     <= s1[SQ_STEPS][1].r[31:0];
      d1[0].rem  <= '0;
      d1[0].num  <= {ell_c, 33'd0};
      d1[0].q    <= '0;
    end
  end

  for (genvar j = 0; j < DIVW; j++) begin : g_div1
    always_ff @(posedge clk) begin
      if (rst) begin
        d1v[j+1] <= 1'b0;
      end else if (adv) begin
        d1v[j+1] <= d1v[j];
        d1x[j+1] <= d1x[j];
        d1e[j+1] <= d1e[j];
        d1c[j+1] <= d1c[j];
        d1[j+1]  <= div_step(d1[j], mag32(d1x[j].rat));
      end
    end
  end

  // Products for the scaled direction and the squares for the knot factor.
  logic             m1v;
  ctx_t             m1x;
  logic [31:0]      m1c;
  logic [2:0][63:0] pm1;
  logic [2:0]       bs1;
  logic [63:0]      e2, o2;
  logic [31:0]      oth_c, om_c;

  assign oth_c = sat_neg(d1[DIVW].q, d1x[DIVW].rat[31]);
  assign om_c  = mag32(oth_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1v <= 1'b0;
    end else if (adv) begin
      m1v <= d1v[DIVW];
      m1x <= d1x[DIVW];
      m1c <= d1c[DIVW];
      for (int i = 0; i < 3; i++) begin
        pm1[i] <= d1x[DIVW].crm[i] * om_c;
        bs1[i] <= d1x[DIVW].ng[i] ^ oth_c[31];
      end
      e2 <= d1e[DIVW] * d1e[DIVW];
      o2 <= om_c * om_c;
    end
  end

  // Three lanes divide by the direction length; one lane takes the knot root.
  logic        d2v  [BD_STEPS+1];
  ctx_t        d2x  [BD_STEPS+1];
  logic [31:0] d2c  [BD_STEPS+1];
  logic [2:0]  d2s  [BD_STEPS+1];
  dv_t         d2   [BD_STEPS+1][3];
  sq_t         d2r  [BD_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d2v[0] <= 1'b0;
    end else if (adv) begin
      d2v[0] <= m1v;
      d2x[0] <= m1x;
      d2c[0] <= m1c;
      d2s[0] <= bs1;
      for (int i = 0; i < 3; i++) begin
        d2[0][i].rem <= {3'd0, pm1[i][61:32]};
        d2[0][i].num <= {pm1[i][31:0], 32'd0};
        d2[0][i].q   <= '0;
      end
      d2r[0] <= {e2 + o2, 64'd0};
    end
  end

  for (genvar j = 0; j < BD_STEPS; j++) begin : g_div2
    always_ff @(posedge clk) begin
      if (rst) begin
        d2v[j+1] <= 1'b0;
      end else if (adv) begin
        d2v[j+1] <= d2v[j];
        d2x[j+1] <= d2x[j];
        d2c[j+1] <= d2c[j];
        d2s[j+1] <= d2s[j];
        for (int i = 0; i < 3; i++) d2[j+1][i] <= div_step(d2[j][i], d2c[j]);
        d2r[j+1] <= isq_step(d2r[j], 64'd1 << (62 - 2*j));
      end
    end
  end

  // Knot factor and the four nonzero knot values.
  logic        f1v, f2v, f3v;
  ctx_t        f1x, f2x, f3x;
  vec3_t       f1b, f2b, f3b;
  logic [48:0] f1hi, f1lo;
  logic [35:0] f2fac;
  logic [3:0][30:0] f3kv;
  logic [3:0][30:0] kv_c;
  logic [49:0] fac_sum;

  assign fac_sum = {1'b0, f1hi} + {17'd0, f1lo[48:16]};

  always_comb begin
    logic [38:0] t;
    for (int q = 0; q < 4; q++) begin
      t = {3'd0, f2fac} * 39'(q + 1) + 39'd2;
      t = t >> 2;
      kv_c[q] = ({25'd0, t} > SAT_MAX) ? SAT_MAX[30:0] : t[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1v <= 1'b0;
      f2v <= 1'b0;
      f3v <= 1'b0;
    end else if (adv) begin
      f1v <= d2v[BD_STEPS];
      f1x <= d2x[BD_STEPS];
      for (int i = 0; i < 3; i++) f1b[i] <= sat_neg(d2[BD_STEPS][i].q, d2s[BD_STEPS][i]);
      f1hi <= d2r[BD_STEPS].r[31:0] * PISQ2_HI;
      f1lo <= d2r[BD_STEPS].r[31:0] * PISQ2_LO + (49'd1 << 29);
      f2v   <= f1v;
      f2x   <= f1x;
      f2b   <= f1b;
      f2fac <= fac_sum[49:14];
      f3v  <= f2v;
      f3x  <= f2x;
      f3b  <= f2b;
      f3kv <= kv_c;
    end
  end

  // Beat sequencer: walks the knots of one ellipse.
  logic             act;
  logic [3:0]       k;
  ctx_t             sx;
  vec3_t            sb;
  logic [3:0][30:0] skv;
  logic             seq_done, ld;

  assign seq_done = act && (k == ((sx.status != ST_OK) ? 4'd0 : KNOT_LAST));
  assign stall    = f3v && act && !seq_done;
  assign ld       = f3v && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      k   <= 4'd0;
    end else if (ld) begin
      act <= 1'b1;
      k   <= 4'd0;
      sx  <= f3x;
      sb  <= f3b;
      skv <= f3kv;
    end else if (seq_done) begin
      act <= 1'b0;
    end else if (act) begin
      k <= k + 4'd1;
    end
  end

  // Result stage one: control point sum and knot select.
  logic                   o1v, o1has, o1odd, o1last, o1d3;
  logic [3:0]             o1k;
  logic [30:0]            o1kv;
  status_t                o1st;
  logic signed [2:0][33:0] o1s;
  logic [2:0][33:0]       s_c;
  logic [30:0]            kvs_c;
  logic                   a_add, a_sub, b_add, b_sub, ok_c;

  always_comb begin
    logic signed [33:0] ca, aa, bb;
    a_add = 1'b0;
    a_sub = 1'b0;
    b_add = 1'b0;
    b_sub = 1'b0;
    case (k)
      4'd0:    a_add = 1'b1;
      4'd1:    begin a_add = 1'b1; b_add = 1'b1; end
      4'd2:    b_add = 1'b1;
      4'd3:    begin a_sub = 1'b1; b_add = 1'b1; end
      4'd4:    a_sub = 1'b1;
      4'd5:    begin a_sub = 1'b1; b_sub = 1'b1; end
      4'd6:    b_sub = 1'b1;
      4'd7:    begin a_add = 1'b1; b_sub = 1'b1; end
      4'd8:    a_add = 1'b1;
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      ca = {{2{sx.c[i][31]}}, sx.c[i]};
      aa = {{2{sx.a[i][31]}}, sx.a[i]};
      bb = {{2{sb[i][31]}}, sb[i]};
      s_c[i] = ca + (a_add ? aa : a_sub ? -aa : 34'sd0) + (b_add ? bb : b_sub ? -bb : 34'sd0);
    end
    if (k < 4'd3) kvs_c = '0;
    else if (k < 4'd5) kvs_c = skv[0];
    else if (k < 4'd7) kvs_c = skv[1];
    else if (k < 4'd9) kvs_c = skv[2];
    else kvs_c = skv[3];
    ok_c = (sx.status == ST_OK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o1v <= 1'b0;
    end else begin
      o1v    <= act;
      o1k    <= ok_c ? k : 4'd0;
      o1kv   <= ok_c ? kvs_c : 31'd0;
      o1has  <= ok_c && (k < POINT_CNT);
      o1odd  <= k[0];
      o1last <= seq_done;
      o1st   <= sx.status;
      o1d3   <= sx.d3;
      for (int i = 0; i < 3; i++) o1s[i] <= (ok_c && (k < POINT_CNT)) ? s_c[i] : 34'sd0;
    end
  end

  // Result stage two: weight on odd points.
  logic                    o2v, o2has, o2odd, o2last, o2d3;
  logic [3:0]              o2k;
  logic [30:0]             o2kv;
  status_t                 o2st;
  logic signed [2:0][33:0] o2s;
  logic [2:0][33:0]        w_c;

  always_comb begin
    logic [33:0] sn;
    logic [63:0] p;
    for (int i = 0; i < 3; i++) begin
      sn = -o1s[i];
      p  = (o1s[i][33] ? sn[32:0] : o1s[i][32:0]) * INV_SQRT2_Q30 + (64'd1 << 29);
      p  = p >> 30;
      w_c[i] = o1odd ? (o1s[i][33] ? -p[33:0] : p[33:0]) : o1s[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o2v <= 1'b0;
    end else begin
      o2v    <= o1v;
      o2k    <= o1k;
      o2kv   <= o1kv;
      o2has  <= o1has;
      o2odd  <= o1odd;
      o2last <= o1last;
      o2st   <= o1st;
      o2d3   <= o1d3;
      o2s    <= w_c;
    end
  end

  // Output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe       <= o2v;
      knot_index   <= o2k;
      knot_value   <= o2kv;
      has_point    <= o2has;
      point_x      <= sat34(o2s[0]);
      point_y      <= sat34(o2s[1]);
      point_z      <= o2d3 ? sat34(o2s[2]) : 32'sd0;
      point_weight <= o2has ? (o2odd ? W_ODD : W_EVEN) : 17'd0;
      status       <= o2st;
      last         <= o2last;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import ers_pkg::*;

  localparam int RANDOM_ITEMS = 165;
  localparam int QUIET_ITEMS  = 30;
  localparam int IDLE_LIMIT   = 3000;
  localparam longint unsigned K_PI      = 64'd3373259426;
  localparam longint unsigned K_SQRT2   = 64'd1518500250;
  localparam longint unsigned K_INVSQ2  = 64'd759250125;
  localparam longint unsigned K_PISQ2   = (K_PI * K_SQRT2 + (64'd1 << 29)) >> 30;
  localparam longint unsigned K_WODD    = (K_INVSQ2 + (64'd1 << 13)) >> 14;
  localparam longint          COORD_MAX = 64'd2147483647;

  typedef struct packed {
    logic signed [31:0] nx, ny, nz, cx, cy, cz, ax, ay, az, rat;
    logic               d3;
  } ellipse_t;

  typedef struct packed {
    logic [3:0]         idx;
    logic [30:0]        kval;
    logic               hp;
    logic signed [31:0] px, py, pz;
    logic [16:0]        w;
    logic [1:0]         st;
    logic               lst;
  } knot_beat_t;

  typedef struct packed {
    ellipse_t e;
    logic     typed;
    status_t  st;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  ellipse_t drv;
  logic strobe;
  knot_beat_t got;

  knot_beat_t pending_beats[$];
  int         fails = 0;
  int         quiet = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ellipse_to_rational_spline_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .normal_x(drv.nx), .normal_y(drv.ny), .normal_z(drv.nz),
    .centre_x(drv.cx), .centre_y(drv.cy), .centre_z(drv.cz),
    .axis_x(drv.ax), .axis_y(drv.ay), .axis_z(drv.az),
    .axis_ratio(drv.rat), .use_3d(drv.d3),
    .strobe(strobe), .knot_index(got.idx), .knot_value(got.kval),
    .has_point(got.hp), .point_x(got.px), .point_y(got.py), .point_z(got.pz),
    .point_weight(got.w), .status(got.st), .last(got.lst)
  );

  function automatic longint unsigned umag(input longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < -COORD_MAX - 1) return -COORD_MAX - 1;
    return v;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Works out the knot beats of one ellipse and queues them.
  task automatic predict_knots(input ellipse_t e);
    longint n[3], c[3], a[3], cr[3], bv[3], pr[3], qr[3];
    longint unsigned mg[3], m, sum, clen, root, hi, lo, factor, kv, v, num, den, full;
    bit ng[3];
    longint ratio, ell, other, s;
    int sh, sa, sb, q;
    knot_beat_t r;
    n = '{longint'(e.nx), longint'(e.ny), longint'(e.nz)};
    c = '{longint'(e.cx), longint'(e.cy), longint'(e.cz)};
    a = '{longint'(e.ax), longint'(e.ay), longint'(e.az)};
    if (!e.d3) begin
      c[2] = 0;
      a[2] = 0;
    end
    ratio = longint'(e.rat);
    if (ratio == 0) ratio = 64'd1 << 16;
    r = '0;
    r.lst = 1'b1;
    sum = umag(a[0]) * umag(a[0]) + umag(a[1]) * umag(a[1]) + umag(a[2]) * umag(a[2]);
    if (sum == 0) begin
      r.st = ST_AXIS_ZERO;
      pending_beats.push_back(r);
      return;
    end
    ell = clamp32(root_floor(sum));
    if (e.d3) begin
      pr = '{n[1] * a[2], n[2] * a[0], n[0] * a[1]};
      qr = '{n[2] * a[1], n[0] * a[2], n[1] * a[0]};
      for (int i = 0; i < 3; i++) begin
        ng[i] = pr[i] < qr[i];
        mg[i] = ng[i] ? longint'(qr[i]) - longint'(pr[i]) : longint'(pr[i]) - longint'(qr[i]);
      end
    end else begin
      mg = '{umag(a[1]), umag(a[0]), 0};
      ng = '{a[1] > 0, a[0] < 0, 1'b0};
    end
    m = mg[0];
    if (mg[1] > m) m = mg[1];
    if (mg[2] > m) m = mg[2];
    if (m == 0) begin
      r.st = ST_PARALLEL;
      pending_beats.push_back(r);
      return;
    end
    sh = 0;
    while (m >= (64'd1 << 31)) begin
      m >>= 1;
      sh++;
    end
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      sh--;
    end
    for (int i = 0; i < 3; i++) begin
      v = sh >= 0 ? (mg[i] >> sh) : (mg[i] << (-sh));
      cr[i] = ng[i] ? -longint'(v) : longint'(v);
    end
    clen = root_floor(umag(cr[0]) * umag(cr[0]) + umag(cr[1]) * umag(cr[1]) +
                      umag(cr[2]) * umag(cr[2]));
    // The second axis length is |A| / ratio, truncated toward zero.
    num = umag(ell);
    den = umag(ratio);
    full = ((num / den) << 16) + (((num % den) << 16) / den);
    if (full > (64'd1 << 40)) full = 64'd1 << 40;
    other = clamp32(((ell < 0) != (ratio < 0)) ? -longint'(full) : longint'(full));
    for (int i = 0; i < 3; i++) bv[i] = clamp32(cr[i] * other / longint'(clen));
    root = root_floor(umag(ell) * umag(ell) + umag(other) * umag(other));
    hi = root * (K_PISQ2 >> 16);
    lo = root * (K_PISQ2 & 64'hffff) + (64'd1 << 29);
    factor = (hi + (lo >> 16)) >> 14;
    for (int k = 0; k < 12; k++) begin
      q = k < 3 ? 0 : k < 5 ? 1 : k < 7 ? 2 : k < 9 ? 3 : 4;
      kv = (factor * q + 2) >> 2;
      if (kv > COORD_MAX) kv = COORD_MAX;
      r = '0;
      r.idx = 4'(k);
      r.kval = kv[30:0];
      r.st = ST_OK;
      r.lst = (k == 11);
      if (k < 9) begin
        sa = (k == 0 || k == 1 || k == 7 || k == 8) ? 1 : (k == 2 || k == 6) ? 0 : -1;
        sb = (k >= 1 && k <= 3) ? 1 : (k >= 5 && k <= 7) ? -1 : 0;
        r.hp = 1'b1;
        for (int i = 0; i < 3; i++) begin
          s = c[i] + sa * a[i] + sb * bv[i];
          if (k % 2 == 1) begin
            v = (umag(s) * K_INVSQ2 + (64'd1 << 29)) >> 30;
            s = s < 0 ? -longint'(v) : longint'(v);
          end
          pr[i] = clamp32(s);
        end
        r.px = pr[0][31:0];
        r.py = pr[1][31:0];
        r.pz = e.d3 ? pr[2][31:0] : 32'd0;
        r.w = (k % 2 == 1) ? K_WODD[16:0] : 17'h10000;
      end
      pending_beats.push_back(r);
    end
  endtask

  // Holds the item on the ports until the block takes it.
  task automatic send_ellipse(input ellipse_t e, input bit typed, input status_t st);
    knot_beat_t r;
    drv <= e;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (typed) begin
      r = '0;
      r.st = st;
      r.lst = 1'b1;
      pending_beats.push_back(r);
    end else begin
      predict_knots(e);
    end
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      3: return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
      4: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function automatic ellipse_t pick_ellipse();
    ellipse_t e;
    e = {pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
         pick_coord(), pick_coord(), pick_coord(), pick_coord(), 32'd0, 1'b0};
    e.d3 = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: e.rat = 32'd0;
      1, 2: e.rat = $urandom;
      3: e.rat = -$urandom_range(32'h4000, 32'h40000);
      default: e.rat = $urandom_range(32'h4000, 32'h40000);
    endcase
    case ($urandom_range(0, 19))
      0: {e.ax, e.ay, e.az} = '0;
      1: begin
        {e.ax, e.ay} = '0;
        e.d3 = 1'b0;
      end
      2: begin
        {e.nx, e.ny, e.nz} = {e.ax, e.ay, e.az};
        e.d3 = 1'b1;
      end
      3: begin
        {e.nx, e.ny, e.nz} = '0;
        e.d3 = 1'b1;
      end
      default: ;
    endcase
    return e;
  endfunction

  stim_row_t directed[] = '{
    // Zero first axis, in 2D and in 3D.
    '{'{32'h10000, 0, 0, 32'h7fffffff, 32'h80000000, 5, 0, 0, 0, 0, 1'b0}, 1'b1, ST_AXIS_ZERO},
    '{'{32'h10000, 0, 0, 1, 2, 3, 0, 0, 0, 32'h10000, 1'b1}, 1'b1, ST_AXIS_ZERO},
    // Axis only along z is zero in 2D, since z is ignored there.
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 32'h10000, 32'h10000, 1'b0}, 1'b1, ST_AXIS_ZERO},
    // Zero normal and a normal parallel to the axis in 3D.
    '{'{0, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 1'b1}, 1'b1, ST_PARALLEL},
    '{'{32'h20000, 32'h40000, 32'h60000, 0, 0, 0, 32'h10000, 32'h20000, 32'h30000,
        0, 1'b1}, 1'b1, ST_PARALLEL},
    // Unit circle, zero ratio meaning one, negative ratio, tiny and huge ratios.
    '{'{0, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 1'b0}, 1'b0, ST_OK},
    '{'{0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 1'b1}, 1'b0, ST_OK},
    '{'{0, 0, 0, 32'h30000, 0, 0, 32'h20000, 32'h10000, 0, 32'hffff0000, 1'b0}, 1'b0, ST_OK},
    '{'{0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 0, 1, 1'b0}, 1'b0, ST_OK},
    '{'{0, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 32'h7fffffff, 1'b0}, 1'b0, ST_OK},
    '{'{0, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 32'h80000000, 1'b1}, 1'b0, ST_OK},
    // Extreme coordinates that saturate the points and knots.
    '{'{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
        32'h80000000, 32'h80000000, 32'h80000000, 32'h8000, 1'b1}, 1'b0, ST_OK},
    '{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
        32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 1'b1}, 1'b0, ST_OK},
    '{'{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
        32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0},
      1'b0, ST_OK},
    '{'{1, 0, 0, 0, 0, 0, 0, 1, 0, 32'h10000, 1'b1}, 1'b0, ST_OK}
  };

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat %p", $time, got);
        fails++;
      end else begin
        if (got !== pending_beats[0]) begin
          $display("%0t: beat mismatch, expected %p, actual %p", $time, pending_beats[0], got);
          fails++;
        end
        void'(pending_beats.pop_front());
      end
    end
  end

  // Counts cycles in which neither an ellipse nor a beat moves.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    drv <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_ellipse(directed[i].e, directed[i].typed, directed[i].st);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < RANDOM_ITEMS - QUIET_ITEMS && $urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      send_ellipse(pick_ellipse(), 1'b0, ST_OK);
    end
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
